/* rtl/core/rcfe_pkg.sv */
// shared types and codes for the command frame exchange block
// used by every module of the block; no dependencies
`default_nettype none

package rcfe_pkg;

  localparam logic [10:0] MAX_PAYLOAD = 11'd1024;
  localparam logic [10:0] HDR_LEN     = 11'd8;
  localparam logic [7:0]  SYNC_TX     = 8'haa;
  localparam logic [7:0]  SYNC_RX     = 8'hbb;
  localparam logic [7:0]  SEQ_TOP     = 8'd254;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QAW         = $clog2(QDEPTH);
  localparam int unsigned HEAD_N      = 6;

  // input operations
  localparam logic [2:0] OP_BEGIN   = 3'd0;
  localparam logic [2:0] OP_PAYLOAD = 3'd1;
  localparam logic [2:0] OP_RXBYTE  = 3'd2;
  localparam logic [2:0] OP_RXIDLE  = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // transaction status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_REPLY = 3'd1;
  localparam logic [2:0] ST_DST      = 3'd2;
  localparam logic [2:0] ST_SRC      = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;
  localparam logic [2:0] ST_SEQ      = 3'd5;
  localparam logic [2:0] ST_HEADER   = 3'd6;

  // job types passed from front to back
  localparam logic [1:0] JOB_BEGIN   = 2'd0;
  localparam logic [1:0] JOB_PAYLOAD = 2'd1;
  localparam logic [1:0] JOB_STATUS  = 2'd2;

  typedef struct packed {
    logic [1:0]  jtype;
    logic [7:0]  seq;
    logic [10:0] flen;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  cmd;
    logic        more;
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  st;
  } rcfe_job_t;

endpackage

`default_nettype wire

/* rtl/core/rcfe_front.sv */
// front end: accepts items, tracks transaction phase and reply, issues jobs
// depends on rcfe_pkg
`default_nettype none

module rcfe_front
  import rcfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_command,
  input  wire logic [10:0] in_payload_length,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [7:0]  src_addr,
  input  wire logic [7:0]  dst_addr,
  input  wire logic [7:0]  pl_cmd,
  input  wire logic        q_full,
  output logic             q_push,
  output rcfe_job_t        q_job
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_REPLY   = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  seq_cnt_r, seq_cnt_nxt;
  logic [7:0]  frame_seq_r, frame_seq_nxt;
  logic [10:0] remain_r, remain_nxt;
  logic [15:0] rx_cnt_r, rx_cnt_nxt;
  logic [7:0]  head_r [HEAD_N];
  logic        head_clr, head_we;

  logic        accept;
  logic [10:0] plen;
  logic [2:0]  verdict;
  logic [7:0]  seq_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign seq_next = (seq_cnt_r == SEQ_TOP) ? 8'd0 : seq_cnt_r + 8'd1;

  always_comb begin
    plen = (in_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_length;
    if (in_command != pl_cmd) begin
      plen = '0;
    end
  end

  // reply verdict, first failing check wins
  always_comb begin
    priority if (rx_cnt_r == 16'd0 || head_r[0] != SYNC_RX) begin
      verdict = ST_HEADER;
    end else if (head_r[1] != frame_seq_r) begin
      verdict = ST_SEQ;
    end else if (rx_cnt_r != {head_r[2], head_r[3]}) begin
      verdict = ST_LENGTH;
    end else if (head_r[4] != src_addr) begin
      verdict = ST_SRC;
    end else if (head_r[5] != dst_addr) begin
      verdict = ST_DST;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    seq_cnt_nxt   = seq_cnt_r;
    frame_seq_nxt = frame_seq_r;
    remain_nxt    = remain_r;
    rx_cnt_nxt    = rx_cnt_r;
    head_clr      = 1'b0;
    head_we       = 1'b0;
    q_push        = 1'b0;
    q_job         = '0;
    q_job.src     = src_addr;
    q_job.dst     = dst_addr;
    q_job.cmd     = in_command;
    q_job.data    = in_data_byte;
    q_job.seq     = seq_cnt_r + 8'd1;
    q_job.flen    = plen + HDR_LEN;
    q_job.more    = (plen != 11'd0);
    if (accept) begin
      unique case (in_op)
        OP_BEGIN: begin
          if (phase_r == PH_IDLE) begin
            q_push        = 1'b1;
            q_job.jtype   = JOB_BEGIN;
            frame_seq_nxt = seq_cnt_r + 8'd1;
            rx_cnt_nxt    = '0;
            head_clr      = 1'b1;
            remain_nxt    = plen;
            phase_nxt     = (plen != 11'd0) ? PH_PAYLOAD : PH_REPLY;
          end
        end
        OP_PAYLOAD: begin
          if (phase_r == PH_PAYLOAD) begin
            q_push      = 1'b1;
            q_job.jtype = JOB_PAYLOAD;
            q_job.fin   = (remain_r <= 11'd1);
            remain_nxt  = (remain_r != 11'd0) ? remain_r - 11'd1 : 11'd0;
            if (remain_r <= 11'd1) begin
              phase_nxt = PH_REPLY;
            end
          end
        end
        OP_RXBYTE: begin
          if (phase_r == PH_REPLY && !(rx_cnt_r == 16'd0 && in_data_byte != SYNC_RX)) begin
            head_we = (rx_cnt_r < 16'(HEAD_N));
            if (rx_cnt_r != 16'hffff) begin
              rx_cnt_nxt = rx_cnt_r + 16'd1;
            end
          end
        end
        OP_RXIDLE, OP_TIMEOUT: begin
          if (phase_r == PH_REPLY) begin
            q_push      = 1'b1;
            q_job.jtype = JOB_STATUS;
            q_job.st    = (in_op == OP_TIMEOUT) ? ST_NO_REPLY : verdict;
            seq_cnt_nxt = seq_next;
            phase_nxt   = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_cnt_r   <= '0;
      frame_seq_r <= '0;
      remain_r    <= '0;
      rx_cnt_r    <= '0;
    end else begin
      phase_r     <= phase_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      frame_seq_r <= frame_seq_nxt;
      remain_r    <= remain_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
    end
  end

  // first six reply bytes
  always_ff @(posedge clk) begin
    if (!rst_n || head_clr) begin
      for (int i = 0; i < HEAD_N; i++) begin
        head_r[i] <= '0;
      end
    end else if (head_we) begin
      head_r[rx_cnt_r[2:0]] <= in_data_byte;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("front phase register holds an unused code");

  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_cnt_r <= SEQ_TOP) else $error("sequence counter out of range");

  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != 11'd0)
    else $error("payload phase with nothing left to send");

endmodule

`default_nettype wire

/* rtl/core/rcfe_queue.sv */
// short job queue between front end and byte sequencer
// depends on rcfe_pkg
`default_nettype none

module rcfe_queue
  import rcfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire rcfe_job_t push_job,
  input  wire logic      pop,
  output logic           full,
  output logic           not_empty,
  output rcfe_job_t      head_job
);

  rcfe_job_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_pop;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("job pushed into a full queue");

endmodule

`default_nettype wire

/* rtl/core/rcfe_back.sv */
// byte sequencer: expands jobs into transmit bytes, checksum and status results
// depends on rcfe_pkg
`default_nettype none

module rcfe_back
  import rcfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  input  wire rcfe_job_t   job,
  output logic             job_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [2:0]       out_status,
  output logic             out_last
);

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic [2:0]  st_r;
  logic        last_r;
  logic [2:0]  step_r;
  logic [7:0]  sum_r, sum_nxt;

  logic        load;
  logic        r_kind;
  logic [7:0]  r_byte;
  logic [2:0]  r_st;
  logic        r_last;
  logic        r_end;
  logic [15:0] total;

  assign load  = job_valid && (!out_valid_r || out_ready);
  assign total = {5'd0, job.flen};

  always_comb begin
    r_kind  = KIND_TX;
    r_byte  = '0;
    r_st    = ST_OK;
    r_last  = 1'b0;
    r_end   = 1'b0;
    sum_nxt = sum_r;
    unique case (job.jtype)
      JOB_BEGIN: begin
        unique case (step_r)
          3'd0: r_byte = SYNC_TX;
          3'd1: r_byte = job.seq;
          3'd2: r_byte = total[15:8];
          3'd3: r_byte = total[7:0];
          3'd4: r_byte = job.src;
          3'd5: r_byte = job.dst;
          3'd6: r_byte = job.cmd;
          default: r_byte = sum_r;
        endcase
        if (step_r == 3'd0) begin
          sum_nxt = SYNC_TX;
        end else if (step_r != 3'd7) begin
          sum_nxt = sum_r + r_byte;
        end
        // with payload the frame goes on in the later payload jobs
        r_end  = (step_r == 3'd7) || (step_r == 3'd6 && job.more);
        r_last = r_end;
      end
      JOB_PAYLOAD: begin
        if (step_r == 3'd0) begin
          r_byte  = job.data;
          sum_nxt = sum_r + job.data;
          r_end   = !job.fin;
        end else begin
          r_byte = sum_r;
          r_end  = 1'b1;
        end
        r_last = r_end;
      end
      JOB_STATUS: begin
        r_kind = KIND_STATUS;
        r_st   = job.st;
        r_last = 1'b1;
        r_end  = 1'b1;
      end
      default: begin
        r_end = 1'b1;
      end
    endcase
  end

  assign job_pop = load && r_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= r_end ? 3'd0 : step_r + 3'd1;
        sum_r       <= sum_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= r_kind;
      byte_r <= r_byte;
      st_r   <= r_st;
      last_r <= r_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_tx_byte = byte_r;
  assign out_status  = st_r;
  assign out_last    = last_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_STATUS |-> last_r && byte_r == 8'd0)
    else $error("status result not marked final");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !job_valid |-> step_r == 3'd0) else $error("sequencer mid-job with no job");

endmodule

`default_nettype wire

/* rtl/core/rs485_command_frame_exchange.sv */
// top level of the command frame exchange master: configuration registers,
// front end, job queue and byte sequencer; depends on rcfe_pkg and rcfe_* modules
`default_nettype none

// A begin item turns into a header of seven bytes, then either the checksum
// (eight results) or, when the command is the payload command and the payload
// length is not zero, one transmit byte per following payload item with the
// checksum after the last. Reply bytes give no result; reply idle or timeout
// gives one status result and closes the transaction. Items are taken every cycle
// while the four-entry job queue has room; results leave at one per cycle from the
// byte sequencer while out_ready is high; a begin item gives eight results, or
// seven with payload, a payload item one or two, a status one. Configuration is
// written through cfg_we, cfg_index and cfg_wdata; indexes 0, 1, 2 are source
// address, destination address and payload command, any other index is ignored.

module rs485_command_frame_exchange
  import rcfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_command,
  input  wire logic [10:0] in_payload_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [2:0]       out_status,
  output logic             out_last
);

  localparam logic [1:0] REG_SRC   = 2'd0;
  localparam logic [1:0] REG_DST   = 2'd1;
  localparam logic [1:0] REG_PLCMD = 2'd2;

  logic [7:0] src_r, dst_r, plcmd_r;

  logic       q_full, q_push, q_not_empty, q_pop;
  rcfe_job_t  push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r   <= 8'd1;
      dst_r   <= 8'd0;
      plcmd_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC:   src_r   <= cfg_wdata;
        REG_DST:   dst_r   <= cfg_wdata;
        REG_PLCMD: plcmd_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rcfe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .src_addr          (src_r),
    .dst_addr          (dst_r),
    .pl_cmd            (plcmd_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (push_job)
  );

  rcfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  rcfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_not_empty),
    .job         (head_job),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_tx_byte (out_tx_byte),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
